FILE: rtl/core/sst_pkg.sv
package sst_pkg;

   // tracker modes, as shown on rsp_mode
   typedef enum logic [1:0] {
      MODE_SEARCH = 2'd0,
      MODE_MAP    = 2'd1,
      MODE_FOUND  = 2'd2,
      MODE_WRAP   = 2'd3
   } mode_type;

   // configuration register indexes
   localparam logic [2:0] CSR_DETECT_LIMIT   = 3'd0;
   localparam logic [2:0] CSR_MAP_SPAN       = 3'd1;
   localparam logic [2:0] CSR_CONFIRM_NEEDED = 3'd2;
   localparam logic [2:0] CSR_LOSE_AFTER     = 3'd3;
   localparam logic [2:0] CSR_RESET_HOLD     = 3'd4;
   localparam logic [2:0] CSR_SWEEP_MAX      = 3'd5;
   localparam logic [2:0] CSR_PULSE_BASE     = 3'd6;
   localparam logic [2:0] CSR_PULSE_GAIN     = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   // reset values of the configuration registers
   localparam logic [7:0]  DETECT_LIMIT_RST   = 8'd60;
   localparam logic [5:0]  MAP_SPAN_RST       = 6'd10;
   localparam logic [3:0]  CONFIRM_NEEDED_RST = 4'd3;
   localparam logic [3:0]  LOSE_AFTER_RST     = 4'd6;
   localparam logic [5:0]  RESET_HOLD_RST     = 6'd30;
   localparam logic [7:0]  SWEEP_MAX_RST      = 8'd180;
   localparam logic [11:0] PULSE_BASE_RST     = 12'd500;
   localparam logic [7:0]  PULSE_GAIN_RST     = 8'd106;

   localparam logic [3:0]  COUNT_MAX  = 4'hF;
   localparam logic [12:0] PULSE_MAX  = 13'h1FFF;
   // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for any 16 bit x
   localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
   localparam int          DIV10_SHIFT = 19;

endpackage

FILE: rtl/core/sweep_scan_object_tracker_top.sv
// Sweep-scan object tracker. Each req transaction carries one range reading
// (cm) and produces exactly one rsp transaction with the commanded servo angle,
// the servo pulse width, the tracker mode and the mapped target. The block is a
// three stage pipeline: an input register, a state update stage whose result
// register also holds the angle*gain product, and an output register where the
// product is divided by ten (reciprocal multiply) and added to the pulse base.
// A new reading is accepted every cycle while the output side keeps taking
// results; each reading passes the input, state update and output registers
// before rsp_valid rises for its result. The tracker state advances once per
// reading in the state update stage, so the next reading always sees the
// state left by the one before. Configuration registers are written through
// the csr port with no handshake and must only be changed while no
// transaction is in flight.
module sweep_scan_object_tracker_top (
   input  logic                              clock,
   input  logic                              reset,
   // reading input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_distance,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_servo_angle,
   output logic [12:0]                       rsp_pulse_us,
   output logic [1:0]                        rsp_mode,
   output logic [7:0]                        rsp_target_angle,
   output logic [7:0]                        rsp_target_distance,
   // configuration write port
   input  logic                              csr_wr_en,
   input  logic [sst_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sst_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration registers
   logic [7:0]  detect_limit_ff;
   logic [5:0]  map_span_ff;
   logic [3:0]  confirm_needed_ff;
   logic [3:0]  lose_after_ff;
   logic [5:0]  reset_hold_ff;
   logic [7:0]  sweep_max_ff;
   logic [11:0] pulse_base_ff;
   logic [7:0]  pulse_gain_ff;

   // tracker state
   sst_pkg::mode_type mode_ff, mode_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  prev_ff;
   logic [7:0]  mdist_ff, mdist_in;
   logic [7:0]  mangle_ff, mangle_in;
   logic [3:0]  hit_ff, hit_in;
   logic [3:0]  miss_ff, miss_in;
   logic [5:0]  wait_ff, wait_in;

   // pipeline registers
   logic        in_valid_ff;
   logic [7:0]  dist_ff;
   logic        mid_valid_ff;
   logic [7:0]  mid_angle_ff;
   logic [1:0]  mid_mode_ff;
   logic [7:0]  mid_tangle_ff;
   logic [7:0]  mid_tdist_ff;
   logic [15:0] mid_prod_ff;
   logic        out_valid_ff;
   logic [7:0]  out_angle_ff;
   logic [12:0] out_pulse_ff;
   logic [1:0]  out_mode_ff;
   logic [7:0]  out_tangle_ff;
   logic [7:0]  out_tdist_ff;

   // stage advance: a stage may load when it is empty or its content moves on
   logic out_ready, mid_ready, step;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign mid_ready = !mid_valid_ff || out_ready;
   assign req_ready = !in_valid_ff || mid_ready;
   assign step      = in_valid_ff && mid_ready;   // reading moves into state update

   // ---------------------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         detect_limit_ff   <= sst_pkg::DETECT_LIMIT_RST;
         map_span_ff       <= sst_pkg::MAP_SPAN_RST;
         confirm_needed_ff <= sst_pkg::CONFIRM_NEEDED_RST;
         lose_after_ff     <= sst_pkg::LOSE_AFTER_RST;
         reset_hold_ff     <= sst_pkg::RESET_HOLD_RST;
         sweep_max_ff      <= sst_pkg::SWEEP_MAX_RST;
         pulse_base_ff     <= sst_pkg::PULSE_BASE_RST;
         pulse_gain_ff     <= sst_pkg::PULSE_GAIN_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            sst_pkg::CSR_DETECT_LIMIT:   detect_limit_ff   <= csr_wdata[7:0];
            sst_pkg::CSR_MAP_SPAN:       map_span_ff       <= csr_wdata[5:0];
            sst_pkg::CSR_CONFIRM_NEEDED: confirm_needed_ff <= csr_wdata[3:0];
            sst_pkg::CSR_LOSE_AFTER:     lose_after_ff     <= csr_wdata[3:0];
            sst_pkg::CSR_RESET_HOLD:     reset_hold_ff     <= csr_wdata[5:0];
            sst_pkg::CSR_SWEEP_MAX:      sweep_max_ff      <= csr_wdata[7:0];
            sst_pkg::CSR_PULSE_BASE:     pulse_base_ff     <= csr_wdata[11:0];
            sst_pkg::CSR_PULSE_GAIN:     pulse_gain_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         dist_ff <= req_distance;
      end
   end

   // ---------------------------------------------------------------------------
   // decision terms, all exact cross-multiplications on 11 bit values
   // ---------------------------------------------------------------------------
   logic [10:0] d_x4, d_x5, d_x6, p_x5, m_x4, m_x5, m_x6;
   logic        drop_seen;      // reading fell clearly below the previous one
   logic        in_band;        // 0.8 <= d/m <= 1.2
   logic        found_miss;
   logic [3:0]  hit_inc, miss_inc;
   logic [5:0]  wait_inc;
   logic        confirm_hit, span_passed, lose_hit, hold_done;
   logic [7:0]  pos_step;       // angle before the wrap check
   logic        wrap_now;

   assign d_x4 = {1'b0, dist_ff, 2'b00};
   assign d_x5 = d_x4 + {3'b000, dist_ff};
   assign d_x6 = d_x4 + {2'b00, dist_ff, 1'b0};
   assign p_x5 = {1'b0, prev_ff, 2'b00} + {3'b000, prev_ff};
   assign m_x4 = {1'b0, mdist_ff, 2'b00};
   assign m_x5 = m_x4 + {3'b000, mdist_ff};
   assign m_x6 = m_x4 + {2'b00, mdist_ff, 1'b0};

   assign drop_seen  = (prev_ff != 8'd0) && (d_x6 <= p_x5) && (dist_ff < detect_limit_ff);
   assign in_band    = (d_x5 >= m_x4) && (d_x5 <= m_x6);
   assign found_miss = !in_band || (dist_ff > detect_limit_ff);

   // counter increments, hit and miss saturating
   assign hit_inc  = (in_band && hit_ff != sst_pkg::COUNT_MAX) ? hit_ff + 4'd1 : hit_ff;
   assign miss_inc = (miss_ff != sst_pkg::COUNT_MAX) ? miss_ff + 4'd1 : miss_ff;
   assign wait_inc = wait_ff + 6'd1;

   assign confirm_hit = hit_inc >= confirm_needed_ff;
   assign span_passed = {1'b0, pos_ff} > ({1'b0, mangle_ff} + {3'b000, map_span_ff});
   assign lose_hit    = miss_inc >= lose_after_ff;
   assign hold_done   = wait_inc >= reset_hold_ff;

   // angle advances in search and map, holds in found, parks at zero in wrap wait
   always_comb begin
      case (mode_ff)
         sst_pkg::MODE_SEARCH: pos_step = pos_ff + 8'd1;
         sst_pkg::MODE_MAP:    pos_step = pos_ff + 8'd1;
         sst_pkg::MODE_FOUND:  pos_step = pos_ff;
         default:              pos_step = 8'd0;
      endcase
   end

   assign wrap_now = pos_step > sweep_max_ff;
   assign pos_in   = wrap_now ? 8'd0 : pos_step;

   // next mode
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         sst_pkg::MODE_SEARCH: begin
            if (drop_seen) mode_in = sst_pkg::MODE_MAP;
         end
         sst_pkg::MODE_MAP: begin
            if (confirm_hit)      mode_in = sst_pkg::MODE_FOUND;
            else if (span_passed) mode_in = sst_pkg::MODE_SEARCH;
         end
         sst_pkg::MODE_FOUND: begin
            if (found_miss && lose_hit) mode_in = sst_pkg::MODE_SEARCH;
         end
         default: begin
            if (hold_done) mode_in = sst_pkg::MODE_SEARCH;
         end
      endcase
      if (wrap_now) mode_in = sst_pkg::MODE_WRAP;
   end

   // next target and counters
   always_comb begin
      mdist_in  = mdist_ff;
      mangle_in = mangle_ff;
      hit_in    = hit_ff;
      miss_in   = miss_ff;
      wait_in   = wait_ff;
      case (mode_ff)
         sst_pkg::MODE_SEARCH: begin
            if (drop_seen) begin
               mdist_in  = dist_ff;
               mangle_in = pos_ff;
               hit_in    = (hit_ff != sst_pkg::COUNT_MAX) ? hit_ff + 4'd1 : hit_ff;
            end
         end
         sst_pkg::MODE_MAP: begin
            if (confirm_hit) begin
               mangle_in = pos_ff;
               hit_in    = 4'd0;
            end else if (span_passed) begin
               hit_in = 4'd0;
            end else begin
               hit_in = hit_inc;
            end
         end
         sst_pkg::MODE_FOUND: begin
            if (found_miss) miss_in = lose_hit ? 4'd0 : miss_inc;
            else            miss_in = 4'd0;
         end
         default: begin
            wait_in = hold_done ? 6'd0 : wait_inc;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= sst_pkg::MODE_SEARCH;
         pos_ff    <= 8'd0;
         prev_ff   <= 8'd0;
         mdist_ff  <= 8'd0;
         mangle_ff <= 8'd0;
         hit_ff    <= 4'd0;
         miss_ff   <= 4'd0;
         wait_ff   <= 6'd0;
      end else if (step) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         prev_ff   <= dist_ff;
         mdist_ff  <= mdist_in;
         mangle_ff <= mangle_in;
         hit_ff    <= hit_in;
         miss_ff   <= miss_in;
         wait_ff   <= wait_in;
      end
   end

   // ---------------------------------------------------------------------------
   // state update result register, also holds angle * gain
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (mid_ready) begin
         mid_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         mid_angle_ff  <= pos_in;
         mid_mode_ff   <= mode_in;
         mid_tangle_ff <= mangle_in;
         mid_tdist_ff  <= mdist_in;
         mid_prod_ff   <= {8'd0, pos_in} * {8'd0, pulse_gain_ff};
      end
   end

   // ---------------------------------------------------------------------------
   // output register: pulse = base + floor(product / 10), saturated
   // ---------------------------------------------------------------------------
   logic [31:0] recip_prod;
   logic [12:0] tenths_q;
   logic [13:0] pulse_sum;
   logic [12:0] pulse_sat;

   assign recip_prod = {16'd0, mid_prod_ff} * {16'd0, sst_pkg::DIV10_RECIP};
   assign tenths_q   = recip_prod[sst_pkg::DIV10_SHIFT +: 13];
   assign pulse_sum  = {2'b00, pulse_base_ff} + {1'b0, tenths_q};
   assign pulse_sat  = pulse_sum[13] ? sst_pkg::PULSE_MAX : pulse_sum[12:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && mid_valid_ff) begin
         out_angle_ff  <= mid_angle_ff;
         out_pulse_ff  <= pulse_sat;
         out_mode_ff   <= mid_mode_ff;
         out_tangle_ff <= mid_tangle_ff;
         out_tdist_ff  <= mid_tdist_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_servo_angle     = out_angle_ff;
   assign rsp_pulse_us        = out_pulse_ff;
   assign rsp_mode            = out_mode_ff;
   assign rsp_target_angle    = out_tangle_ff;
   assign rsp_target_distance = out_tdist_ff;

endmodule

FILE: rtl/core/sst_checker.sv
module sst_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [7:0]                        rsp_servo_angle,
   input logic [12:0]                       rsp_pulse_us,
   input logic [1:0]                        rsp_mode,
   input logic [7:0]                        rsp_target_angle
);

   // no result straight out of reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // wrap wait parks the servo at zero
   a_wrap_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode == sst_pkg::MODE_WRAP) |-> rsp_servo_angle == 8'd0)
      else $error("wrap wait with nonzero angle");

   // found holds one degree past the confirmed target
   a_found_angle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode == sst_pkg::MODE_FOUND) |->
         rsp_servo_angle == rsp_target_angle + 8'd1)
      else $error("found angle does not follow target");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_servo_angle)
         && $stable(rsp_pulse_us)))
      else $error("stalled result changed");

endmodule

bind sweep_scan_object_tracker_top sst_checker u_sst_checker (.*);

FILE: tb/sst_tracker_checker.sv
`timescale 1ns / 100ps

module sst_tracker_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_distance,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [7:0]                      rsp_servo_angle,
   input  logic [12:0]                     rsp_pulse_us,
   input  logic [1:0]                      rsp_mode,
   input  logic [7:0]                      rsp_target_angle,
   input  logic [7:0]                      rsp_target_distance,
   input  logic                            csr_wr_en,
   input  logic [sst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sst_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              pending_count
);
   import sst_pkg::*;

   typedef struct packed {
      logic [7:0]  servo_angle;
      logic [12:0] pulse_us;
      mode_type    mode;
      logic [7:0]  target_angle;
      logic [7:0]  target_distance;
   } readout_type;

   // register copies
   logic [7:0]  cfg_detect_limit;
   logic [5:0]  cfg_map_span;
   logic [3:0]  cfg_confirm_needed;
   logic [3:0]  cfg_lose_after;
   logic [5:0]  cfg_reset_hold;
   logic [7:0]  cfg_sweep_max;
   logic [11:0] cfg_pulse_base;
   logic [7:0]  cfg_pulse_gain;

   // tracker state
   mode_type    trk_mode;
   logic [7:0]  trk_angle;
   logic [7:0]  trk_prev;
   logic [7:0]  trk_map_dist;
   logic [7:0]  trk_map_angle;
   logic [3:0]  trk_hits;
   logic [3:0]  trk_misses;
   logic [5:0]  trk_wait;

   readout_type pending_readouts [$];

   function automatic bit within_band(input logic [7:0] d, input logic [7:0] m);
      return (5 * int'(d) >= 4 * int'(m)) && (5 * int'(d) <= 6 * int'(m));
   endfunction

   task automatic track_reading(input logic [7:0] reading, output readout_type res);
      int pulse;
      case (trk_mode)
         MODE_SEARCH: begin
            if (trk_prev != 8'd0 && 6 * int'(reading) <= 5 * int'(trk_prev) &&
                reading < cfg_detect_limit) begin
               trk_map_dist  = reading;
               trk_map_angle = trk_angle;
               trk_mode      = MODE_MAP;
               if (trk_hits != COUNT_MAX) trk_hits = trk_hits + 4'd1;
            end
            trk_angle = trk_angle + 8'd1;
         end
         MODE_MAP: begin
            if (within_band(reading, trk_map_dist) && trk_hits != COUNT_MAX)
               trk_hits = trk_hits + 4'd1;
            if (trk_hits >= cfg_confirm_needed) begin
               trk_mode      = MODE_FOUND;
               trk_map_angle = trk_angle;
               trk_hits      = 4'd0;
            end else if (int'(trk_angle) > int'(trk_map_angle) + int'(cfg_map_span)) begin
               trk_mode = MODE_SEARCH;
               trk_hits = 4'd0;
            end
            trk_angle = trk_angle + 8'd1;
         end
         MODE_FOUND: begin
            if (!within_band(reading, trk_map_dist) || reading > cfg_detect_limit) begin
               if (trk_misses != COUNT_MAX) trk_misses = trk_misses + 4'd1;
               if (trk_misses >= cfg_lose_after) begin
                  trk_misses = 4'd0;
                  trk_mode   = MODE_SEARCH;
               end
            end else begin
               trk_misses = 4'd0;
            end
         end
         default: begin
            trk_angle = 8'd0;
            trk_wait  = trk_wait + 6'd1;
            if (trk_wait >= cfg_reset_hold) begin
               trk_wait = 6'd0;
               trk_mode = MODE_SEARCH;
            end
         end
      endcase
      if (trk_angle > cfg_sweep_max) begin
         trk_angle = 8'd0;
         trk_mode  = MODE_WRAP;
      end
      trk_prev = reading;

      pulse = int'(cfg_pulse_base) + (int'(trk_angle) * int'(cfg_pulse_gain)) / 10;
      if (pulse > int'(PULSE_MAX)) pulse = int'(PULSE_MAX);

      res.servo_angle     = trk_angle;
      res.pulse_us        = 13'(pulse);
      res.mode            = trk_mode;
      res.target_angle    = trk_map_angle;
      res.target_distance = trk_map_dist;
   endtask

   function automatic int field_differs(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      readout_type want;
      int          errs;
      errs = fail_count;
      if (reset) begin
         cfg_detect_limit   = DETECT_LIMIT_RST;
         cfg_map_span       = MAP_SPAN_RST;
         cfg_confirm_needed = CONFIRM_NEEDED_RST;
         cfg_lose_after     = LOSE_AFTER_RST;
         cfg_reset_hold     = RESET_HOLD_RST;
         cfg_sweep_max      = SWEEP_MAX_RST;
         cfg_pulse_base     = PULSE_BASE_RST;
         cfg_pulse_gain     = PULSE_GAIN_RST;
         trk_mode      = MODE_SEARCH;
         trk_angle     = 8'd0;
         trk_prev      = 8'd0;
         trk_map_dist  = 8'd0;
         trk_map_angle = 8'd0;
         trk_hits      = 4'd0;
         trk_misses    = 4'd0;
         trk_wait      = 6'd0;
         pending_readouts.delete();
         errs = 0;
      end else begin
         // results leave before new readings are counted
         if (rsp_valid && rsp_ready) begin
            if (pending_readouts.size() == 0) begin
               $error("rsp transaction with no reading awaiting its result");
               errs++;
            end else begin
               want = pending_readouts.pop_front();
               errs += field_differs("servo_angle", want.servo_angle, rsp_servo_angle);
               errs += field_differs("pulse_us", want.pulse_us, rsp_pulse_us);
               errs += field_differs("mode", want.mode, rsp_mode);
               errs += field_differs("target_angle", want.target_angle, rsp_target_angle);
               errs += field_differs("target_distance", want.target_distance,
                                     rsp_target_distance);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DETECT_LIMIT:   cfg_detect_limit   = csr_wdata[7:0];
               CSR_MAP_SPAN:       cfg_map_span       = csr_wdata[5:0];
               CSR_CONFIRM_NEEDED: cfg_confirm_needed = csr_wdata[3:0];
               CSR_LOSE_AFTER:     cfg_lose_after     = csr_wdata[3:0];
               CSR_RESET_HOLD:     cfg_reset_hold     = csr_wdata[5:0];
               CSR_SWEEP_MAX:      cfg_sweep_max      = csr_wdata[7:0];
               CSR_PULSE_BASE:     cfg_pulse_base     = csr_wdata[11:0];
               CSR_PULSE_GAIN:     cfg_pulse_gain     = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            track_reading(req_distance, want);
            pending_readouts.push_back(want);
         end
      end
      fail_count    <= errs;
      pending_count <= pending_readouts.size();
   end

endmodule

FILE: tb/tb_sweep_scan_object_tracker_top.sv
`timescale 1ns / 100ps

module tb_sweep_scan_object_tracker_top;
   import sst_pkg::*;

   // one full set of tracker registers
   typedef struct {
      logic [7:0]  detect_limit;
      logic [5:0]  map_span;
      logic [3:0]  confirm_needed;
      logic [3:0]  lose_after;
      logic [5:0]  reset_hold;
      logic [7:0]  sweep_max;
      logic [11:0] pulse_base;
      logic [7:0]  pulse_gain;
   } tracker_setting_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_distance = 8'd0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_servo_angle;
   logic [12:0]            rsp_pulse_us;
   logic [1:0]             rsp_mode;
   logic [7:0]             rsp_target_angle;
   logic [7:0]             rsp_target_distance;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int fail_count;
   int pending_count;

   // idle percentages for sender and receiver
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;

   // reading generator state
   logic [7:0] cur_limit = DETECT_LIMIT_RST;
   int         burst_left = 0;
   int         burst_center = 1;
   bit         burst_object = 1'b0;

   // directed readings: edge values, a drop into mapping, a band hit to found,
   // misses back to searching, a mapping timeout and a wrap with a short hold
   logic [7:0] directed_a [21] = '{
      8'd0, 8'd255, 8'd100, 8'd50, 8'd70, 8'd40, 8'd60, 8'd61, 8'd48, 8'd255,
      8'd0, 8'd30, 8'd20, 8'd255, 8'd255, 8'd255, 8'd255, 8'd200, 8'd100, 8'd100,
      8'd100
   };
   // zero confirm, zero lose and zero hold counts
   logic [7:0] directed_b [5] = '{8'd200, 8'd100, 8'd100, 8'd255, 8'd7};

   sweep_scan_object_tracker_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_distance        (req_distance),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_servo_angle     (rsp_servo_angle),
      .rsp_pulse_us        (rsp_pulse_us),
      .rsp_mode            (rsp_mode),
      .rsp_target_angle    (rsp_target_angle),
      .rsp_target_distance (rsp_target_distance),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   sst_tracker_checker tracker_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_distance        (req_distance),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_servo_angle     (rsp_servo_angle),
      .rsp_pulse_us        (rsp_pulse_us),
      .rsp_mode            (rsp_mode),
      .rsp_target_angle    (rsp_target_angle),
      .rsp_target_distance (rsp_target_distance),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   // 10 ns clock
   always #5 clock = ~clock;

   // receiver stalls at random, one decision per cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // one register write per cycle; the caller lowers the enable after a batch
   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // writes every register, only called while nothing is in flight
   task automatic apply_setting(input tracker_setting_t s);
      csr_put(CSR_DETECT_LIMIT, CSR_DATA_W'(s.detect_limit));
      csr_put(CSR_MAP_SPAN, CSR_DATA_W'(s.map_span));
      csr_put(CSR_CONFIRM_NEEDED, CSR_DATA_W'(s.confirm_needed));
      csr_put(CSR_LOSE_AFTER, CSR_DATA_W'(s.lose_after));
      csr_put(CSR_RESET_HOLD, CSR_DATA_W'(s.reset_hold));
      csr_put(CSR_SWEEP_MAX, CSR_DATA_W'(s.sweep_max));
      csr_put(CSR_PULSE_BASE, CSR_DATA_W'(s.pulse_base));
      csr_put(CSR_PULSE_GAIN, CSR_DATA_W'(s.pulse_gain));
      csr_wr_en <= 1'b0;
      cur_limit = s.detect_limit;
   endtask

   // one req transaction, with an optional random gap in front of it
   task automatic send_reading(input logic [7:0] d);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_distance <= d;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending until every outstanding result has come back
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      // pipeline is three deep, so idle on after the drain
      repeat (8) @(posedge clock);
   endtask

   // phase-dependent idling: sender light / receiver heavy, then swapped, then none
   task automatic pick_idling(input int phase);
      if (phase < 3) begin
         send_idle_pct = 10;
         rsp_idle_pct  = 57;
      end else if (phase < 6) begin
         send_idle_pct = 57;
         rsp_idle_pct  = 10;
      end else begin
         send_idle_pct = 0;
         rsp_idle_pct  = 0;
      end
   endtask

   // bursts of far background and near objects with jitter around the band
   task automatic next_reading(output logic [7:0] d);
      int lim;
      int v;
      if (burst_left == 0) begin
         if ($urandom_range(0, 9) < 7) begin
            burst_object = 1'b1;
            lim = int'(cur_limit);
            if (lim < 2) burst_center = $urandom_range(1, 40);
            else burst_center = $urandom_range(1, (lim > 200) ? 200 : lim - 1);
            burst_left = $urandom_range(2, 16);
         end else begin
            burst_object = 1'b0;
            burst_left = $urandom_range(1, 8);
         end
      end
      burst_left--;
      if ($urandom_range(0, 9) == 0) begin
         // plain noise
         d = 8'($urandom);
      end else if (burst_object) begin
         v = burst_center * $urandom_range(75, 125) / 100;
         d = (v > 255) ? 8'd255 : 8'(v);
      end else begin
         d = 8'($urandom_range(128, 255));
      end
   endtask

   task automatic make_random_setting(output tracker_setting_t s);
      s.detect_limit   = 8'($urandom_range(20, 255));
      s.map_span       = 6'($urandom);
      s.confirm_needed = 4'($urandom);
      s.lose_after     = 4'($urandom);
      s.reset_hold     = 6'($urandom);
      // short sweeps so that wraps come often
      s.sweep_max      = 8'($urandom_range(10, 80));
      s.pulse_base     = 12'($urandom);
      s.pulse_gain     = 8'($urandom);
   endtask

   // a random phase with one mid-phase drain
   task automatic run_random(input int count);
      logic [7:0] d;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) quiesce();
         next_reading(d);
         send_reading(d);
      end
   endtask

   initial begin
      tracker_setting_t s;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part
      pick_idling(0);
      s = '{8'd60, 6'd3, 4'd2, 4'd2, 6'd2, 8'd12, 12'd4095, 8'd255};
      apply_setting(s);
      foreach (directed_a[i]) send_reading(directed_a[i]);
      quiesce();
      s = '{8'd255, 6'd0, 4'd0, 4'd0, 6'd0, 8'd254, 12'd0, 8'd0};
      apply_setting(s);
      foreach (directed_b[i]) send_reading(directed_b[i]);
      quiesce();

      // reset values written back explicitly
      pick_idling(1);
      s = '{DETECT_LIMIT_RST, MAP_SPAN_RST, CONFIRM_NEEDED_RST, LOSE_AFTER_RST,
            RESET_HOLD_RST, SWEEP_MAX_RST, PULSE_BASE_RST, PULSE_GAIN_RST};
      apply_setting(s);
      run_random(200);
      quiesce();

      // all registers at their top value; no wrap, so the angle rolls over 255
      pick_idling(2);
      s = '{8'd255, 6'd63, 4'd15, 4'd15, 6'd63, 8'd255, 12'd4095, 8'd255};
      apply_setting(s);
      run_random(350);
      quiesce();

      // all registers zero
      pick_idling(3);
      s = '{8'd0, 6'd0, 4'd0, 4'd0, 6'd0, 8'd0, 12'd0, 8'd0};
      apply_setting(s);
      run_random(100);
      quiesce();

      // random settings across the remaining idling regimes
      for (int phase = 4; phase < 9; phase++) begin
         pick_idling(phase);
         make_random_setting(s);
         apply_setting(s);
         run_random(120);
         quiesce();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/sst_pkg.sv
rtl/core/sweep_scan_object_tracker_top.sv
rtl/core/sst_checker.sv
tb/sst_tracker_checker.sv
tb/tb_sweep_scan_object_tracker_top.sv
